[sv/hkrb_pkg.sv]
// shared types, constants and codes for the keyboard report builder
// no dependencies; used by every module of the block
package hkrb_pkg;

  localparam int KEY_SLOTS = 6;
  localparam int OUT_KEYS  = 6;
  localparam int KEY_W     = 8;

  localparam logic [4:0]  TYPE_SYNC      = 5'd0;
  localparam logic [4:0]  TYPE_MISC      = 5'd4;
  localparam logic [15:0] CODE_SCAN      = 16'd4;
  localparam logic [15:0] USAGE_PAGE_KEY = 16'h0700;
  localparam logic [7:0]  USAGE_MOD_LO   = 8'hE0;
  localparam logic [7:0]  USAGE_MOD_HI   = 8'hE7;

  localparam logic [1:0] ST_IGNORED = 2'd0;
  localparam logic [1:0] ST_UPDATED = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_SEND    = 2'd3;

  localparam logic [2:0] KIND_IGNORE  = 3'd0;
  localparam logic [2:0] KIND_SEND    = 3'd1;
  localparam logic [2:0] KIND_INVALID = 3'd2;
  localparam logic [2:0] KIND_MOD     = 3'd3;
  localparam logic [2:0] KIND_KEY     = 3'd4;

  typedef struct packed {
    logic [4:0]         event_type;
    logic [15:0]        event_code;
    logic signed [31:0] event_value;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] modifier_bits;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
  } out_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [KEY_W-1:0] usage;
  } dec_t;

  // passed from slot to slot along the row
  typedef struct packed {
    logic found;
    logic remove;
  } chain_t;

endpackage

[sv/hkrb_event_decode.sv]
// classifies one input event: sync, ignored, invalid, modifier or key
// depends on hkrb_pkg
module hkrb_event_decode (
  input  hkrb_pkg::in_t  ev,
  output hkrb_pkg::dec_t dec
);

  logic [7:0]  usage;
  logic [15:0] page;

  assign usage = ev.event_value[7:0];
  assign page  = ev.event_value[23:8];

  always_comb begin
    dec.usage = usage;
    if (ev.event_type == hkrb_pkg::TYPE_SYNC) begin
      dec.kind = hkrb_pkg::KIND_SEND;
    end else if (ev.event_type == hkrb_pkg::TYPE_MISC) begin
      if (ev.event_code != hkrb_pkg::CODE_SCAN || page != hkrb_pkg::USAGE_PAGE_KEY) begin
        dec.kind = hkrb_pkg::KIND_INVALID;
      end else if (usage >= hkrb_pkg::USAGE_MOD_LO && usage <= hkrb_pkg::USAGE_MOD_HI) begin
        dec.kind = hkrb_pkg::KIND_MOD;
      end else begin
        dec.kind = hkrb_pkg::KIND_KEY;
      end
    end else begin
      dec.kind = hkrb_pkg::KIND_IGNORE;
    end
  end

endmodule

[sv/hkrb_slot_cell.sv]
// one key slot of the report: holds a usage and takes part in the toggle chain
// depends on hkrb_pkg
module hkrb_slot_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic [hkrb_pkg::KEY_W-1:0] code,
  input  hkrb_pkg::chain_t         chain_in,
  input  logic [hkrb_pkg::KEY_W-1:0] next_key,
  output hkrb_pkg::chain_t         chain_out,
  output logic [hkrb_pkg::KEY_W-1:0] key,
  output logic [hkrb_pkg::KEY_W-1:0] key_nxt
);

  logic [hkrb_pkg::KEY_W-1:0] key_r;
  logic match;
  logic empty;

  assign match = (key_r == code);
  assign empty = (key_r == '0);
  assign key   = key_r;

  // first slot that holds the code or is empty decides remove or insert
  assign chain_out.found  = chain_in.found | match | empty;
  assign chain_out.remove = chain_in.found ? chain_in.remove : match;

  always_comb begin
    key_nxt = key_r;
    if (en) begin
      if (!chain_in.found && (match || empty)) begin
        key_nxt = match ? next_key : code;
      end else if (chain_in.found && chain_in.remove) begin
        key_nxt = next_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

endmodule

[sv/hid_keyboard_report_builder.sv]
// keyboard report builder top level: event decode, modifier register, slot row
// depends on hkrb_pkg, hkrb_event_decode and hkrb_slot_cell
//
// Takes one input event per request and returns exactly one result per event.
// When an event is taken, the modifier register and the row of
// six slot cells update at the accepting edge, and the result (status plus the
// report as it stands after the event) sits in the output register from the
// next cycle. The row of slot cells resolves a key toggle by passing a
// found/remove flag from slot 0 upward and each slot's key down to its
// neighbour, so that ripple sets the cycle time. A new event is taken while
// the output register is empty or being drained, so the sustained rate is one
// event per cycle while out_ready does not stall the output.
module hid_keyboard_report_builder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  hkrb_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output hkrb_pkg::out_t out_data
);

  hkrb_pkg::dec_t   dec;
  hkrb_pkg::chain_t chain [hkrb_pkg::KEY_SLOTS+1];
  logic [hkrb_pkg::KEY_W-1:0] keys [hkrb_pkg::KEY_SLOTS];
  logic [hkrb_pkg::KEY_W-1:0] key_nxt [hkrb_pkg::KEY_SLOTS];
  logic [hkrb_pkg::KEY_W-1:0] out_keys [hkrb_pkg::OUT_KEYS];

  logic       accept;
  logic       key_en;
  logic [3:0] mod_r;
  logic [3:0] mod_nxt;
  logic [1:0] status;
  logic       out_valid_r;
  hkrb_pkg::out_t out_data_r;
  hkrb_pkg::out_t out_data_nxt;

  assign in_ready = rst_n & (~out_valid_r | out_ready);
  assign accept   = in_valid & in_ready;
  assign key_en   = accept & (dec.kind == hkrb_pkg::KIND_KEY);

  hkrb_event_decode u_decode (
    .ev  (in_data),
    .dec (dec)
  );

  assign chain[0] = '{found: 1'b0, remove: 1'b0};

  for (genvar i = 0; i < hkrb_pkg::KEY_SLOTS; i++) begin : g_slot
    logic [hkrb_pkg::KEY_W-1:0] next_key;
    if (i == hkrb_pkg::KEY_SLOTS - 1) begin : g_last
      assign next_key = '0;
    end else begin : g_mid
      assign next_key = keys[i+1];
    end
    hkrb_slot_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (key_en),
      .code      (dec.usage),
      .chain_in  (chain[i]),
      .next_key  (next_key),
      .chain_out (chain[i+1]),
      .key       (keys[i]),
      .key_nxt   (key_nxt[i])
    );
  end

  for (genvar k = 0; k < hkrb_pkg::OUT_KEYS; k++) begin : g_out
    if (k < hkrb_pkg::KEY_SLOTS) begin : g_have
      assign out_keys[k] = key_nxt[k];
    end else begin : g_none
      assign out_keys[k] = '0;
    end
  end

  always_comb begin
    mod_nxt = mod_r;
    if (accept && dec.kind == hkrb_pkg::KIND_MOD) begin
      mod_nxt = mod_r ^ (4'b0001 << dec.usage[1:0]);
    end
  end

  always_comb begin
    case (dec.kind)
      hkrb_pkg::KIND_SEND:    status = hkrb_pkg::ST_SEND;
      hkrb_pkg::KIND_INVALID: status = hkrb_pkg::ST_INVALID;
      hkrb_pkg::KIND_MOD:     status = hkrb_pkg::ST_UPDATED;
      hkrb_pkg::KIND_KEY:     status = chain[hkrb_pkg::KEY_SLOTS].found ?
                                       hkrb_pkg::ST_UPDATED : hkrb_pkg::ST_INVALID;
      default:                status = hkrb_pkg::ST_IGNORED;
    endcase
  end

  always_comb begin
    out_data_nxt.status        = status;
    out_data_nxt.modifier_bits = mod_nxt;
    out_data_nxt.key_slot_0    = out_keys[0];
    out_data_nxt.key_slot_1    = out_keys[1];
    out_data_nxt.key_slot_2    = out_keys[2];
    out_data_nxt.key_slot_3    = out_keys[3];
    out_data_nxt.key_slot_4    = out_keys[4];
    out_data_nxt.key_slot_5    = out_keys[5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mod_r <= mod_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/hkrb_checker.sv]
// port-level checks on the keyboard report builder, bound to the top level
// depends on hkrb_pkg and hid_keyboard_report_builder
module hkrb_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input hkrb_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input hkrb_pkg::out_t out_data
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // every request leaves a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("request gave no result");

  // a stalled result blocks new requests
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken over a stalled result");

  // events that are neither sync nor misc come back as ignored
  a_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.event_type != hkrb_pkg::TYPE_SYNC &&
    in_data.event_type != hkrb_pkg::TYPE_MISC
    |=> out_data.status == hkrb_pkg::ST_IGNORED)
    else $error("ignored event not reported as ignored");

endmodule

bind hid_keyboard_report_builder hkrb_checker u_hkrb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
